// ===== sv/stream_pattern_replace_defines.svh =====
// ---------------------------------------------------------------------------
// Stream pattern replace: assertion macros
// Shared assertion shorthands. The enclosing module provides clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef STREAM_PATTERN_REPLACE_DEFINES_SVH
`define STREAM_PATTERN_REPLACE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spr_pkg.sv =====
// ---------------------------------------------------------------------------
// Stream pattern replace: package
// Shared constants, register indexes and types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spr_pkg;

	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

	// Next-value source of a window cell.
	localparam logic [1:0] SEL_KEEP = 2'd0;
	localparam logic [1:0] SEL_NBR  = 2'd1;
	localparam logic [1:0] SEL_FAR  = 2'd2;

	typedef struct packed {
		logic       en;
		logic [1:0] sel;
	} cell_ctl_t;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} emit_entry_t;

endpackage

// ===== sv/spr_cell.sv =====
// ---------------------------------------------------------------------------
// Stream pattern replace: window cell
// Holds one pending byte, compares it with its pattern byte and loads
// its own, its neighbor's or a far byte on each accepted beat that is not an end beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spr_cell (
	input  logic              clk,
	input  spr_pkg::cell_ctl_t ctl,
	input  logic              ins,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        pat_byte,
	input  logic [7:0]        nbr,
	input  logic [7:0]        far,
	output logic [7:0]        ext,
	output logic              eq,
	output logic [7:0]        q
);

	logic [7:0] byte_q;

	// The cell at the fill position sees the incoming byte.
	assign ext = ins ? in_byte : byte_q;
	assign eq  = (ext == pat_byte);
	assign q   = byte_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.sel)
				spr_pkg::SEL_KEEP: byte_q <= ext;
				spr_pkg::SEL_NBR:  byte_q <= nbr;
				spr_pkg::SEL_FAR:  byte_q <= far;
				default:           byte_q <= ext;
			endcase
		end
	end

endmodule

// ===== sv/spr_emitter.sv =====
// ---------------------------------------------------------------------------
// Stream pattern replace: output emitter
// Shift line of output entries that drains one beat per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spr_emitter #(
	parameter int NE = spr_pkg::MAX_PATTERN_DEF,
	parameter int EW = $clog2(NE + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  spr_pkg::emit_entry_t [NE-1:0]  load_ent,
	input  logic [EW-1:0]                  load_cnt,
	output logic                           can_load,
	output logic                           out_valid,
	input  logic                           out_ready,
	output spr_pkg::emit_entry_t           out_ent
);

	spr_pkg::emit_entry_t [NE-1:0] ent_q;
	logic [EW-1:0]                 rem_q;

	assign out_valid = (rem_q != '0);
	assign out_ent   = ent_q[0];
	// Free now, or the final beat leaves in this cycle.
	assign can_load  = (rem_q == '0) || ((rem_q == EW'(1)) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= load_cnt;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - EW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_ent;
		end else if (out_valid && out_ready) begin
			for (int i = 0; i < NE - 1; i++) begin
				ent_q[i] <= ent_q[i + 1];
			end
		end
	end

endmodule

// ===== sv/stream_pattern_replace.sv =====
// ---------------------------------------------------------------------------
// Stream pattern replace
// Replaces every leftmost, non-overlapping occurrence of a byte pattern in a
// byte stream with a replacement string, and closes each string with a
// terminator beat.
// ---------------------------------------------------------------------------
//
//  Channel   Dir   Payload                              Accepted when
//  s_*       in    tdata = in_byte, tlast = in_end      s_tvalid && s_tready
//  m_*       out   tdata = out_byte, tlast = out_last   m_tvalid && m_tready
//  cfg_*     in    cfg_index, cfg_data                  cfg_valid && cfg_ready
//
//  A source beat is taken every cycle as long as each beat yields at most one
//  output beat and m_tready stays high. A beat that yields k output beats (a
//  replacement, or a flush plus terminator) holds the output port until all
//  k have left; the emitter shift line drains one beat per cycle while
//  m_tready is high. One descriptor register lets a new source beat enter
//  while earlier output still waits. Reset clears all control state at once,
//  with no clearing pass; cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stream_pattern_replace_defines.svh"

module stream_pattern_replace #(
	parameter int MAX_PATTERN     = spr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = spr_pkg::MAX_REPLACEMENT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Source stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_byte
	input  logic                           s_tlast,   // in_end
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tlast,   // out_last
	// Configuration writes.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Window count width holds MAX_PATTERN itself; emitter holds the larger
	// of a flush (window plus terminator) and a replacement.
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int RW = $clog2(MAX_REPLACEMENT + 1);
	localparam int NE = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int EW = $clog2(NE + 1);

	// -----------------------------------------------------------------------
	// Configuration registers. Writes are always taken; unknown indexes are
	// dropped.
	// -----------------------------------------------------------------------
	logic [63:0] pattern_bytes_q;
	logic [3:0]  pattern_length_q;
	logic [63:0] replacement_bytes_q;
	logic [3:0]  replacement_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= 4'd1;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spr_pkg::REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				spr_pkg::REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[3:0];
				spr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				spr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: a zero pattern length counts as one, and both
	// lengths saturate at the size of their storage.
	logic [CW-1:0] plen;
	logic [RW-1:0] rlen;

	always_comb begin
		if (pattern_length_q == '0) begin
			plen = CW'(1);
		end else if (32'(pattern_length_q) > MAX_PATTERN) begin
			plen = CW'(MAX_PATTERN);
		end else begin
			plen = CW'(pattern_length_q);
		end
		if (32'(replacement_length_q) > MAX_REPLACEMENT) begin
			rlen = RW'(MAX_REPLACEMENT);
		end else begin
			rlen = RW'(replacement_length_q);
		end
	end

	// -----------------------------------------------------------------------
	// Handshake bookkeeping.
	// -----------------------------------------------------------------------
	logic s_accept;
	logic slot_vld_q;
	logic emit_can_load;
	logic emit_take;

	assign emit_take = slot_vld_q && emit_can_load;
	// The descriptor slot is free, or is handed to the emitter in this cycle.
	assign s_tready  = !slot_vld_q || emit_take;
	assign s_accept  = s_tvalid && s_tready;

	// -----------------------------------------------------------------------
	// Window: a row of cells, oldest byte in cell 0. The incoming byte is
	// seen by the cell at the fill position, so the compare covers the
	// window as it stands after the byte is appended.
	// -----------------------------------------------------------------------
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              cnt_p1;
	logic [8*MAX_PATTERN-1:0]   ext_flat;
	logic [8*MAX_PATTERN-1:0]   far_flat;
	logic [7:0]                 win_q   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]     mv;
	logic                       decide;
	logic                       match;
	spr_pkg::cell_ctl_t         cell_ctl;

	assign cnt_p1 = count_q + CW'(1);
	assign decide = (cnt_p1 >= plen);
	assign match  = decide && (&mv);

	// After a match the rest of the window moves down by the pattern length.
	assign far_flat = ext_flat >> {plen, 3'b000};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] pat_b;
		logic [7:0] nbr_b;
		logic       eq;

		if (i < 8) begin : g_pat
			assign pat_b = pattern_bytes_q[8*i +: 8];
		end else begin : g_pat_zero
			assign pat_b = '0;
		end

		if (i < MAX_PATTERN - 1) begin : g_nbr
			assign nbr_b = ext_flat[8*(i+1) +: 8];
		end else begin : g_nbr_end
			assign nbr_b = '0;
		end

		// Positions past the pattern length do not take part in the match.
		assign mv[i] = eq || (CW'(i) >= plen);

		spr_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.ins      (count_q == CW'(i)),
			.in_byte  (s_tdata),
			.pat_byte (pat_b),
			.nbr      (nbr_b),
			.far      (far_flat[8*i +: 8]),
			.ext      (ext_flat[8*i +: 8]),
			.eq       (eq),
			.q        (win_q[i])
		);
	end

	always_comb begin
		cell_ctl.en = s_accept && !s_tlast;
		if (!decide) begin
			cell_ctl.sel = spr_pkg::SEL_KEEP;
		end else if (match) begin
			cell_ctl.sel = spr_pkg::SEL_FAR;
		end else begin
			cell_ctl.sel = spr_pkg::SEL_NBR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_accept) begin
			if (s_tlast) begin
				count_q <= '0;
			end else if (!decide) begin
				count_q <= cnt_p1;
			end else if (match) begin
				count_q <= cnt_p1 - plen;
			end else begin
				count_q <= count_q;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Output descriptor for the beat being accepted: nothing, the oldest
	// byte, the replacement string, or a flush of the window followed by
	// the terminator.
	// -----------------------------------------------------------------------
	spr_pkg::emit_entry_t [NE-1:0] desc_ent;
	logic [EW-1:0]                 desc_cnt;
	spr_pkg::emit_entry_t [NE-1:0] slot_ent_q;
	logic [EW-1:0]                 slot_cnt_q;
	logic [7:0]                    repl_b [NE];

	for (genvar i = 0; i < NE; i++) begin : g_repl
		if (i < 8) begin : g_byte
			assign repl_b[i] = replacement_bytes_q[8*i +: 8];
		end else begin : g_zero
			assign repl_b[i] = '0;
		end
	end

	always_comb begin
		desc_ent = '0;
		desc_cnt = '0;
		if (s_tlast) begin
			for (int i = 0; i < NE; i++) begin
				if (i < MAX_PATTERN && i < int'(count_q)) begin
					desc_ent[i].data = win_q[i < MAX_PATTERN ? i : 0];
				end else if (i == int'(count_q)) begin
					desc_ent[i].last = 1'b1;
				end
			end
			desc_cnt = EW'(count_q) + EW'(1);
		end else if (match) begin
			for (int i = 0; i < NE; i++) begin
				if (i < MAX_REPLACEMENT) begin
					desc_ent[i].data = repl_b[i];
				end
			end
			desc_cnt = EW'(rlen);
		end else if (decide) begin
			desc_ent[0].data = ext_flat[7:0];
			desc_cnt         = EW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= 1'b0;
		end else if (s_accept && (desc_cnt != '0)) begin
			slot_vld_q <= 1'b1;
		end else if (emit_take) begin
			slot_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			slot_ent_q <= desc_ent;
			slot_cnt_q <= desc_cnt;
		end
	end

	// -----------------------------------------------------------------------
	// Emitter.
	// -----------------------------------------------------------------------
	spr_pkg::emit_entry_t out_ent;

	spr_emitter #(
		.NE (NE),
		.EW (EW)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_take),
		.load_ent  (slot_ent_q),
		.load_cnt  (slot_cnt_q),
		.can_load  (emit_can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ent   (out_ent)
	);

	assign m_tdata = out_ent.data;
	assign m_tlast = out_ent.last;

	// -----------------------------------------------------------------------
	// Assertions.
	// -----------------------------------------------------------------------
	// The window never fills up completely between beats.
	`SPR_ASSERT_NOW(a_window_bound, 1'b1, 32'(count_q) < MAX_PATTERN, "window count overflow")
	// An end beat always leaves a descriptor behind.
	`SPR_ASSERT_NEXT(a_end_desc, s_accept && s_tlast, slot_vld_q && (count_q == '0),
		"end beat lost its flush")
	// A source byte grows the window by at most one.
	`SPR_ASSERT_NEXT(a_window_grow, s_accept && !s_tlast,
		32'(count_q) <= 32'($past(count_q)) + 1, "window grew by more than one")
	// The terminator carries a zero byte.
	`SPR_ASSERT_NOW(a_term_zero, m_tvalid && m_tlast, m_tdata == '0, "terminator byte not zero")

endmodule

// ===== bench/stream_pattern_replace_tb.sv =====
// ---------------------------------------------------------------------------
// Stream pattern replace: self-checking testbench
// Feeds byte strings into the source stream and checks every result beat
// against a cycle-free model of the find-and-replace. Random stalls sit on
// both streams. The configuration changes between phases, once the block
// has gone idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_pattern_replace_tb;

	localparam int NUM_REGS = 4;
	localparam int LAST_INDEX = (1 << spr_pkg::CFG_IDX_W) - 1;
	localparam int SETTLE_CYCLES = 16;
	// Two-letter alphabet for phases that should hit many near matches.
	localparam logic [7:0] LETTER_A = 8'h61;
	localparam logic [7:0] LETTER_B = 8'h62;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} src_beat_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [7:0]                     m_tdata;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [spr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Model copy of the registers and of the window of pending bytes.
	logic [63:0] cfg_pat;
	logic [3:0]  cfg_pat_len;
	logic [63:0] cfg_rep;
	logic [3:0]  cfg_rep_len;
	logic [7:0]  win [spr_pkg::MAX_PATTERN_DEF];
	int          win_fill;

	src_beat_t            src_queue [$];
	spr_pkg::emit_entry_t out_due [$];
	int                   src_pushed = 0;
	int                   src_accepted = 0;
	int                   mismatches = 0;
	bit                   src_taken = 1'b0;
	int                   src_gap = 0;
	int                   sink_gap = 0;
	int                   src_idle_pct = 0;
	int                   sink_idle_pct = 0;

	stream_pattern_replace u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] in_byte
		.s_tlast   (s_tlast),   // in_end
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] out_byte
		.m_tlast   (m_tlast),   // out_last
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// A zero pattern length acts as one, and long lengths saturate.
	function automatic int eff_pat_len();
		if (cfg_pat_len == 0)
			return 1;
		if (cfg_pat_len > spr_pkg::MAX_PATTERN_DEF)
			return spr_pkg::MAX_PATTERN_DEF;
		return int'(cfg_pat_len);
	endfunction

	function automatic void apply_reg_write(input logic [spr_pkg::CFG_IDX_W-1:0] idx,
		input logic [spr_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			spr_pkg::REG_PATTERN_BYTES:      cfg_pat = val;
			spr_pkg::REG_PATTERN_LENGTH:     cfg_pat_len = val[3:0];
			spr_pkg::REG_REPLACEMENT_BYTES:  cfg_rep = val;
			spr_pkg::REG_REPLACEMENT_LENGTH: cfg_rep_len = val[3:0];
			default: ;  // Unmapped indexes leave every register alone.
		endcase
	endfunction

	function automatic void push_result(input logic [7:0] b, input logic last);
		spr_pkg::emit_entry_t e;
		e.data = b;
		e.last = last;
		out_due.push_back(e);
	endfunction

	// Work out the result beats that one source beat causes.
	function automatic void apply_source_beat(input logic [7:0] b, input logic fin);
		int  plen;
		int  rlen;
		int  drop;
		int  i;
		bit  hit;
		if (fin) begin
			// End of string: flush the window in order, then the terminator.
			for (i = 0; i < win_fill; i++)
				push_result(win[i], 1'b0);
			win_fill = 0;
			push_result(8'h00, 1'b1);
			return;
		end
		if (win_fill >= spr_pkg::MAX_PATTERN_DEF) begin
			push_result(win[0], 1'b0);
			for (i = 0; i + 1 < win_fill; i++)
				win[i] = win[i + 1];
			win_fill--;
		end
		win[win_fill] = b;
		win_fill++;
		plen = eff_pat_len();
		if (win_fill < plen)
			return;
		hit = 1'b1;
		for (i = 0; i < plen; i++)
			if (win[i] != cfg_pat[8*i +: 8])
				hit = 1'b0;
		if (hit) begin
			rlen = (cfg_rep_len > spr_pkg::MAX_REPLACEMENT_DEF)
				? spr_pkg::MAX_REPLACEMENT_DEF : int'(cfg_rep_len);
			for (i = 0; i < rlen; i++)
				push_result(cfg_rep[8*i +: 8], 1'b0);
			drop = plen;
		end else begin
			push_result(win[0], 1'b0);
			drop = 1;
		end
		for (i = 0; i + drop < win_fill; i++)
			win[i] = win[i + drop];
		win_fill -= drop;
	endfunction

	// Everything that happens at a rising edge is observed here, in one place,
	// so that a source beat is modeled before a result in the same edge is
	// checked.
	always @(posedge clk) begin : scoreboard
		spr_pkg::emit_entry_t want;
		src_taken = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				src_taken = 1'b1;
				src_accepted++;
				apply_source_beat(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (out_due.size() == 0) begin
					$error("unexpected result beat: out_byte=%02h out_last=%0b",
						m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = out_due.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("out_last: expected %0b, got %0b", want.last, m_tlast);
						mismatches++;
					end
				end
			end
		end
	end

	// Source driver. A beat stays on the bus until it is taken; between beats
	// the sender may go quiet for a burst of cycles.
	always @(negedge clk) begin : src_drive
		src_beat_t nxt;
		if (arst_n && !(s_tvalid && !src_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (src_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if ($urandom_range(0, 99) < src_idle_pct) begin
				src_gap = $urandom_range(0, 14);
				s_tvalid <= 1'b0;
			end else begin
				nxt = src_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.data;
				s_tlast <= nxt.fin;
			end
		end
	end

	// Result sink: back pressure in random bursts.
	always @(negedge clk) begin : sink_drive
		if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			sink_gap = $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_src(input logic [7:0] b, input logic fin);
		src_beat_t sb;
		sb.data = b;
		sb.fin = fin;
		src_queue.push_back(sb);
		src_pushed++;
	endtask

	// Leaves cfg_valid high; the caller lowers it after its last write so that
	// back-to-back writes never lower and raise it in the same step.
	task automatic write_reg(input logic [spr_pkg::CFG_IDX_W-1:0] idx,
		input logic [spr_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued beat is taken and every result has come out,
	// then give the emitter time to finish work that has no result yet.
	task automatic drain();
		while (src_accepted != src_pushed || out_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Full length word: random upper bits, chosen low nibble.
	function automatic logic [63:0] len_word(input logic [3:0] nib);
		logic [63:0] w;
		w = {$urandom, $urandom};
		w[3:0] = nib;
		return w;
	endfunction

	// One random string: mostly whole pattern copies and near misses built
	// from pattern bytes, with stray bytes and ends in between.
	task automatic queue_text(input int n, input bit alpha);
		int          plen;
		int          k;
		int          i;
		int          cut;
		int          r;
		logic [7:0]  b;
		plen = eff_pat_len();
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				for (i = 0; i < plen; i++)
					push_src(cfg_pat[8*i +: 8], 1'b0);
				k += plen;
			end else if (r < 45 && plen > 1) begin
				// Broken copy: a proper prefix of the pattern.
				cut = $urandom_range(1, plen - 1);
				for (i = 0; i < cut; i++)
					push_src(cfg_pat[8*i +: 8], 1'b0);
				k += cut;
			end else if (r < 53) begin
				push_src(8'($urandom), 1'b1);
				k++;
			end else begin
				if (alpha)
					b = $urandom_range(0, 1) ? LETTER_A : LETTER_B;
				else if (r < 75)
					b = cfg_pat[8*$urandom_range(0, plen - 1) +: 8];
				else
					b = 8'($urandom);
				push_src(b, 1'b0);
				k++;
			end
		end
	endtask

	initial begin : stimulus
		logic [63:0] w;
		bit          alpha;
		int          i;
		int          r;
		int          n;

		cfg_pat = '0;
		cfg_pat_len = 4'd1;
		cfg_rep = '0;
		cfg_rep_len = 4'd0;
		win_fill = 0;
		for (i = 0; i < spr_pkg::MAX_PATTERN_DEF; i++)
			win[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-byte pattern of zero, replaced by nothing,
		// so every zero byte is deleted.
		src_idle_pct = 10;
		sink_idle_pct = 10;
		push_src(8'h00, 1'b0);
		push_src(8'hFF, 1'b0);
		push_src(8'h00, 1'b0);
		push_src(8'hFF, 1'b1);
		drain();

		// Longest pattern and replacement, both given with lengths that
		// saturate; the end item then finds an empty window.
		write_reg(spr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, len_word(4'hF));
		write_reg(spr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
		write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, len_word(4'hF));
		end_writes();
		for (i = 0; i < spr_pkg::MAX_PATTERN_DEF; i++)
			push_src(8'hFF, 1'b0);
		push_src(8'h00, 1'b1);
		drain();

		// Pattern length zero behaves as one. A write to an unmapped index
		// must change nothing.
		write_reg(spr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FF7F);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, len_word(4'h0));
		write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, len_word(4'h1));
		write_reg(spr_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, LAST_INDEX)),
			{$urandom, $urandom});
		end_writes();
		push_src(8'h7F, 1'b0);
		push_src(8'h80, 1'b0);
		push_src(8'h7F, 1'b1);
		drain();

		// Bytes left pending, then the pattern shortened under them: the next
		// byte decides on the first two pending bytes only.
		write_reg(spr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0403_0201);
		write_reg(spr_pkg::REG_PATTERN_LENGTH, len_word(4'h4));
		write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, len_word(4'h2));
		end_writes();
		push_src(8'h01, 1'b0);
		push_src(8'h02, 1'b0);
		push_src(8'h03, 1'b0);
		drain();
		write_reg(spr_pkg::REG_PATTERN_LENGTH, len_word(4'h2));
		end_writes();
		push_src(8'h07, 1'b0);
		push_src(8'h00, 1'b1);
		drain();

		// Random phases. Each one may rewrite any register, sends a string
		// set, and drains before the next write, so the sender always pauses
		// for the last result at a phase boundary.
		while (src_pushed < 360) begin
			alpha = ($urandom_range(0, 99) < 30);
			if ($urandom_range(0, 99) < 70) begin
				w = {$urandom, $urandom};
				if (alpha)
					for (i = 0; i < 8; i++)
						w[8*i +: 8] = $urandom_range(0, 1) ? LETTER_A : LETTER_B;
				write_reg(spr_pkg::REG_PATTERN_BYTES, w);
			end
			if ($urandom_range(0, 99) < 70) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					w = len_word(4'h0);
				else if (r < 20)
					w = len_word(4'($urandom_range(spr_pkg::MAX_PATTERN_DEF + 1, 15)));
				else
					w = len_word(4'($urandom_range(1, spr_pkg::MAX_PATTERN_DEF)));
				write_reg(spr_pkg::REG_PATTERN_LENGTH, w);
			end
			if ($urandom_range(0, 99) < 70)
				write_reg(spr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
			if ($urandom_range(0, 99) < 70) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					w = len_word(4'h0);
				else if (r < 25)
					w = len_word(4'($urandom_range(spr_pkg::MAX_REPLACEMENT_DEF + 1, 15)));
				else
					w = len_word(4'($urandom_range(1, spr_pkg::MAX_REPLACEMENT_DEF)));
				write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, w);
			end
			if ($urandom_range(0, 99) < 10)
				write_reg(spr_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, LAST_INDEX)),
					{$urandom, $urandom});
			end_writes();

			// Some phases run with no idling at all.
			r = $urandom_range(0, 2);
			src_idle_pct = (r == 0) ? 0 : (r == 1) ? 8 : 20;
			r = $urandom_range(0, 2);
			sink_idle_pct = (r == 0) ? 0 : (r == 1) ? 8 : 20;

			n = $urandom_range(20, 45);
			queue_text(n, alpha);
			// Most phases close the string; the others leave bytes pending
			// into the next configuration.
			if ($urandom_range(0, 99) < 70)
				push_src(8'($urandom), 1'b1);
			drain();
		end

		// Closing stretch at full rate on both sides.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		queue_text(30, 1'b0);
		push_src(8'($urandom), 1'b1);
		drain();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Slowest clean run: about 410 beats, each up to eight results, each
	// result behind a sink stall, plus sender gaps and phase drains, stays
	// inside the limit that this watchdog sets.
	initial begin : watchdog
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
